// ----- rtl/arp_responder_cache_unit_assert.svh -----
// assertion macros for the arp responder cache unit and its checker
// no dependencies; taken in by `include in the checker file
`ifndef ARP_RESPONDER_CACHE_UNIT_ASSERT_SVH
`define ARP_RESPONDER_CACHE_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ARC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arc assertion failed");

// next-cycle implication, disabled during reset
`define ARC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arc assertion failed");

`endif

// ----- rtl/arc_pkg.sv -----
// shared types and constants of the arp responder cache unit
// no dependencies; used by the top level and the checker
package arc_pkg;

  // default number of cache entries, entry 0 included
  localparam int unsigned TABLE_DEPTH_DEF = 16;

  // configuration port
  localparam int unsigned CFG_AW = 4;
  localparam int unsigned CFG_DW = 64;
  localparam logic REG_MY_IP  = 1'b0;
  localparam logic REG_MY_MAC = 1'b1;
  localparam logic [31:0] MY_IP_RST  = 32'h0A00020E;
  localparam logic [47:0] MY_MAC_RST = 48'h0;

  // operation codes of an input item
  localparam logic [1:0] OP_RECV   = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_SEND   = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_NONE    = 2'd0;
  localparam logic [1:0] KIND_REPLY   = 2'd1;
  localparam logic [1:0] KIND_REQUEST = 2'd2;
  localparam logic [1:0] KIND_LOOKUP  = 2'd3;

  // arp opcodes
  localparam logic [15:0] ARP_OPC_REQUEST   = 16'd1;
  localparam logic [1:0]  FRAME_OPC_REQUEST = 2'd1;
  localparam logic [1:0]  FRAME_OPC_REPLY   = 2'd2;

  // fixed broadcast mapping of entry 0
  localparam logic [31:0] BCAST_IP  = 32'hFFFF_FFFF;
  localparam logic [47:0] BCAST_MAC = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] arp_op;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
    logic [47:0] target_mac;
    logic [31:0] target_ip;
  } arc_in_t;

  typedef struct packed {
    logic [1:0]  out_kind;
    logic [47:0] frame_dest_mac;
    logic [1:0]  frame_opcode;
    logic [47:0] frame_sender_mac;
    logic [31:0] frame_sender_ip;
    logic [47:0] frame_target_mac;
    logic [31:0] frame_target_ip;
    logic        lookup_hit;
    logic [47:0] lookup_mac;
  } arc_out_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } cache_entry_t;

endpackage

// ----- rtl/arc_chan_if.sv -----
// valid/ready channel carrying one item of a given payload type
// no dependencies; the payload type is set where the channel is instantiated
interface arc_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ----- rtl/arc_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module arc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

// ----- rtl/arp_responder_cache_unit.sv -----
// arp responder with address cache: receive, lookup and send operations
// flow: an accepted item passes through the exec state, for a lookup the scan state, which reads
//   one cache entry per cycle (up to TABLE_DEPTH-1 entries), and the done state, whose result
//   is then registered on the output; one item is taken at a time, a new one only once the last
//   has left the done state, which stalls while the output holds an item that is not taken
// reset: synchronous active low; control and configuration registers to reset values, cache empty but for entry 0
module arp_responder_cache_unit #(
  parameter int unsigned TABLE_DEPTH = arc_pkg::TABLE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  arc_chan_if.sink                   in_ch,
  arc_chan_if.source                 out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [arc_pkg::CFG_AW-1:0] paddr,
  input  logic [arc_pkg::CFG_DW-1:0] pwdata,
  output logic [arc_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);
  import arc_pkg::*;

  localparam int unsigned IDXW = $clog2(TABLE_DEPTH);
  localparam int unsigned ENTRY_W = $bits(cache_entry_t);
  localparam logic [IDXW-1:0] FIRST_IDX = IDXW'(1);
  localparam logic [IDXW-1:0] LAST_IDX  = IDXW'(TABLE_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [31:0]   my_ip_r;
  logic [47:0]   my_mac_r;
  logic          cfg_wr;
  logic          cfg_sel;

  logic [1:0]    state_r, state_nxt;
  arc_in_t       item_r;
  arc_out_t      res_r, res_nxt;
  arc_out_t      out_r;
  logic          out_valid_r;
  logic          out_load;
  logic [IDXW-1:0] slot_r, slot_nxt;
  logic          wrapped_r, wrapped_nxt;
  logic [IDXW-1:0] scan_r, scan_nxt;
  logic [IDXW-1:0] next_idx;

  logic          ram_we;
  logic          ram_re;
  logic [IDXW-1:0] ram_raddr;
  cache_entry_t  ram_wdata;
  cache_entry_t  ram_rdata;

  // configuration registers
  assign pready  = 1'b1;
  assign cfg_sel = paddr[CFG_AW-1];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_ip_r  <= MY_IP_RST;
      my_mac_r <= MY_MAC_RST;
    end else if (cfg_wr) begin
      if (cfg_sel == REG_MY_IP) begin
        my_ip_r <= pwdata[31:0];
      end else begin
        my_mac_r <= pwdata[47:0];
      end
    end
  end

  assign prdata = (cfg_sel == REG_MY_IP) ? {32'b0, my_ip_r} : {16'b0, my_mac_r};

  // cache ram, entry 0 is the fixed broadcast mapping and never stored
  assign ram_wdata = '{ip: item_r.sender_ip, mac: item_r.sender_mac};
  assign next_idx  = scan_r + 1'b1;
  assign ram_raddr = (state_r == S_EXEC) ? FIRST_IDX : next_idx;

  arc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_cache_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // control: one item at a time through exec, scan and done
  always_comb begin
    state_nxt   = state_r;
    slot_nxt    = slot_r;
    wrapped_nxt = wrapped_r;
    scan_nxt    = scan_r;
    res_nxt     = res_r;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_nxt   = '0;
        state_nxt = S_DONE;
        unique case (item_r.operation)
          OP_RECV: begin
            // learn the sender into the ring slot
            ram_we = 1'b1;
            if (slot_r == LAST_IDX) begin
              slot_nxt    = FIRST_IDX;
              wrapped_nxt = 1'b1;
            end else begin
              slot_nxt = slot_r + 1'b1;
            end
            if (item_r.arp_op == ARP_OPC_REQUEST && item_r.target_ip == my_ip_r) begin
              res_nxt.out_kind         = KIND_REPLY;
              res_nxt.frame_dest_mac   = item_r.sender_mac;
              res_nxt.frame_opcode     = FRAME_OPC_REPLY;
              res_nxt.frame_sender_mac = my_mac_r;
              res_nxt.frame_sender_ip  = my_ip_r;
              res_nxt.frame_target_mac = item_r.sender_mac;
              res_nxt.frame_target_ip  = item_r.sender_ip;
            end
          end
          OP_SEND: begin
            res_nxt.out_kind         = KIND_REQUEST;
            res_nxt.frame_dest_mac   = BCAST_MAC;
            res_nxt.frame_opcode     = FRAME_OPC_REQUEST;
            res_nxt.frame_sender_mac = my_mac_r;
            res_nxt.frame_sender_ip  = my_ip_r;
            res_nxt.frame_target_mac = item_r.target_mac;
            res_nxt.frame_target_ip  = item_r.target_ip;
          end
          OP_LOOKUP: begin
            res_nxt.out_kind = KIND_LOOKUP;
            if (item_r.target_ip == BCAST_IP) begin
              res_nxt.lookup_hit = 1'b1;
              res_nxt.lookup_mac = BCAST_MAC;
            end else if (wrapped_r || FIRST_IDX < slot_r) begin
              // start the scan at entry 1
              ram_re    = 1'b1;
              scan_nxt  = FIRST_IDX;
              state_nxt = S_SCAN;
            end
          end
          default: begin
            // undefined operation: an all-zero result of kind none is sent
          end
        endcase
      end
      S_SCAN: begin
        // entries are valid as a prefix of the ring until it wraps
        if (ram_rdata.ip == item_r.target_ip) begin
          res_nxt.lookup_hit = 1'b1;
          res_nxt.lookup_mac = ram_rdata.mac;
          state_nxt          = S_DONE;
        end else if (scan_r == LAST_IDX || !(wrapped_r || next_idx < slot_r)) begin
          state_nxt = S_DONE;
        end else begin
          ram_re   = 1'b1;
          scan_nxt = next_idx;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_load    = (state_r == S_DONE) && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = (state_r == S_IDLE);

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= FIRST_IDX;
      wrapped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      slot_r    <= slot_nxt;
      wrapped_r <= wrapped_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item, working result and output payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r <= in_ch.payload;
    end
    scan_r <= scan_nxt;
    res_r  <= res_nxt;
    if (out_load) begin
      out_r <= res_r;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.payload = out_r;
endmodule

// ----- rtl/arc_checker.sv -----
// port-level checks of the arp responder cache unit, bound to its top level
// depends on arc_pkg and arp_responder_cache_unit_assert.svh
`include "arp_responder_cache_unit_assert.svh"

module arc_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input arc_pkg::arc_out_t out_item
);
  import arc_pkg::*;

  logic frame_zero;
  logic lookup_zero;
  logic lookup_kind;
  logic reply_ok;
  logic no_frame;

  // frame fields are cleared on items that carry no frame
  assign frame_zero = out_item.frame_dest_mac == '0 && out_item.frame_opcode == '0 &&
                      out_item.frame_sender_mac == '0 && out_item.frame_sender_ip == '0 &&
                      out_item.frame_target_mac == '0 && out_item.frame_target_ip == '0;
  assign lookup_zero = !out_item.lookup_hit && out_item.lookup_mac == '0;
  assign lookup_kind = out_item.out_kind == KIND_LOOKUP;
  assign no_frame = out_item.out_kind == KIND_NONE || lookup_kind;
  // a reply goes back to the requester that it names as target
  assign reply_ok = out_item.frame_opcode == FRAME_OPC_REPLY &&
                    out_item.frame_target_mac == out_item.frame_dest_mac;

  `ARC_ASSERT_NOW(a_frame_zero, clk, rst_n, out_valid && no_frame, frame_zero)
  `ARC_ASSERT_NOW(a_lookup_zero, clk, rst_n, out_valid && !lookup_kind, lookup_zero)
  `ARC_ASSERT_NOW(a_reply_ok, clk, rst_n, out_valid && out_item.out_kind == KIND_REPLY, reply_ok)
  `ARC_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)
  `ARC_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))
endmodule

bind arp_responder_cache_unit arc_checker u_arc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_item  (out_ch.payload)
);
